// ===== hw/rtl/hcb_pkg.sv =====
// Shared constants for the Huffman code builder.
// Field widths of the code words and the parameter defaults.
// No dependencies.
package hcb_pkg;

  localparam int SYMBOL_W            = 8;
  localparam int CODE_W              = 15;
  localparam int LEN_W               = 4;
  localparam int EXP_W               = 24;
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

  localparam int MAX_SYMBOLS_DEFAULT = 16;
  localparam int WEIGHT_BITS_DEFAULT = 16;

endpackage

// ===== hw/rtl/hcb_sym_if.sv =====
// Channel that carries (symbol, weight) words into the code builder.
// Uses hcb_pkg for the symbol width.
interface hcb_sym_if #(
  parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [hcb_pkg::SYMBOL_W-1:0]  symbol;
  logic [WEIGHT_BITS-1:0]        weight;
  logic                          last_symbol;

  modport source (output valid, symbol, weight, last_symbol, input ready);
  modport sink   (input valid, symbol, weight, last_symbol, output ready);
endinterface

// ===== hw/rtl/hcb_code_if.sv =====
// Channel that carries one code word per loaded symbol out of the builder.
// Uses hcb_pkg for the field widths.
interface hcb_code_if;
  logic                          valid;
  logic                          ready;
  logic [hcb_pkg::SYMBOL_W-1:0]  out_symbol;
  logic [hcb_pkg::CODE_W-1:0]    code_bits;
  logic [hcb_pkg::LEN_W-1:0]     code_length;
  logic [hcb_pkg::EXP_W-1:0]     expected_length;
  logic                          last_code;

  modport source (output valid, out_symbol, code_bits, code_length, expected_length,
                  last_code, input ready);
  modport sink   (input valid, out_symbol, code_bits, code_length, expected_length,
                  last_code, output ready);
endinterface

// ===== hw/rtl/hcb_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued. No dependencies.
module hcb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/huffman_code_builder_core.sv =====
// Huffman code builder: node RAM, code RAM and the build sequencer.
// Depends on hcb_pkg, hcb_sym_if, hcb_code_if and hcb_ram.
//
// Usage:
//   symbols carries (symbol, weight, last_symbol) words, one per cycle while
//   ready is high. Up to MAX_SYMBOLS words are stored; further words are
//   dropped, but a dropped word with last_symbol still starts the build.
//   On last_symbol the block stops taking words, builds the tree and then
//   sends one word per loaded symbol on codes, in load order, with last_code
//   set on the final one. After that word is taken it is empty and loads again.
// Steps:
//   Load stores words as above. Build: each merge scans the node RAM once over
//   all nodes so far; the code walk visits each internal node (read, zero-child
//   write, one-child write), the length sum each leaf (read, multiply, add).
//   Each result then passes node/code RAM read, output load and handshake. The
//   single read port of the node RAM sets the scan length.
// Reset clears the sequencer, the live bits and the fill count; RAM contents
//   are not cleared. When the receiver stalls, the current result holds in the
//   output register and the sequencer waits.
module huffman_code_builder_core #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEFAULT,
  parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  hcb_sym_if.sink    symbols,
  hcb_code_if.source codes
);

  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W     = $clog2(2 * MAX_SYMBOLS);
  localparam int DEPTH_W    = $clog2(MAX_SYMBOLS);
  localparam int NWT_W      = WEIGHT_BITS + DEPTH_W;
  localparam int SYM_W      = hcb_pkg::SYMBOL_W;
  localparam int CODE_W     = hcb_pkg::CODE_W;
  localparam int LEN_W      = hcb_pkg::LEN_W;
  localparam int EXP_W      = hcb_pkg::EXP_W;
  localparam int NWORD_W    = SYM_W + 2 * NODE_W + NWT_W;
  localparam int CWORD_W    = DEPTH_W + CODE_W;
  localparam int PROD_W     = WEIGHT_BITS + DEPTH_W;
  localparam int ACC_W      = ((PROD_W > EXP_W) ? PROD_W : EXP_W) + 1;

  typedef enum logic [12:0] {
    S_LOAD      = 13'b0000000000001,
    S_SCAN      = 13'b0000000000010,
    S_MERGE     = 13'b0000000000100,
    S_ROOT      = 13'b0000000001000,
    S_WALK_RD   = 13'b0000000010000,
    S_WALK_ZERO = 13'b0000000100000,
    S_WALK_ONE  = 13'b0000001000000,
    S_SUM_RD    = 13'b0000010000000,
    S_SUM_MUL   = 13'b0000100000000,
    S_SUM_ACC   = 13'b0001000000000,
    S_OUT_RD    = 13'b0010000000000,
    S_OUT_LOAD  = 13'b0100000000000,
    S_OUT_HOLD  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      n_leaves;
  logic [NODE_W-1:0]     total;
  logic [NODE_COUNT-1:0] live;
  logic [NODE_W-1:0]     scan_idx;
  logic                  pend_v;
  logic [NODE_W-1:0]     pend_idx;
  logic                  b1_v, b2_v;
  logic [NODE_W-1:0]     b1_idx, b2_idx;
  logic [NWT_W-1:0]      b1_w, b2_w;
  logic [NODE_W-1:0]     walk_idx;
  logic [CNT_W-1:0]      k;
  logic [PROD_W-1:0]     prod;
  logic [EXP_W-1:0]      acc;

  logic                  out_valid;
  logic [SYM_W-1:0]      out_symbol;
  logic [CODE_W-1:0]     out_code;
  logic [LEN_W-1:0]      out_len;
  logic                  out_last;

  // RAM ports
  logic               n_we, n_re, c_we, c_re;
  logic [NODE_W-1:0]  n_wa, n_ra, c_wa, c_ra;
  logic [NWORD_W-1:0] n_wd, n_rd;
  logic [CWORD_W-1:0] c_wd, c_rd;

  logic [SYM_W-1:0]   nd_sym;
  logic [NODE_W-1:0]  nd_zc, nd_oc;
  logic [NWT_W-1:0]   nd_wt;
  logic [DEPTH_W-1:0] cd_depth;
  logic [CODE_W-1:0]  cd_code;

  logic                     sym_acc;
  logic                     store_ok;
  logic [CNT_W-1:0]         count_inc;
  logic [NODE_W-1:0]        node_goal;
  logic [NWT_W-1:0]         merged_w;
  logic [DEPTH_W-1:0]       child_depth;
  logic [DEPTH_W+LEN_W-1:0] depth_ext;
  logic [ACC_W-1:0]         acc_sum;
  logic                     k_is_last;
  logic [NODE_COUNT-1:0]    live_merged;

  assign nd_sym   = n_rd[NWORD_W-1 -: SYM_W];
  assign nd_zc    = n_rd[2*NODE_W+NWT_W-1 -: NODE_W];
  assign nd_oc    = n_rd[NODE_W+NWT_W-1 -: NODE_W];
  assign nd_wt    = n_rd[NWT_W-1:0];
  assign cd_depth = c_rd[CWORD_W-1 -: DEPTH_W];
  assign cd_code  = c_rd[CODE_W-1:0];

  assign symbols.ready = (state == S_LOAD);
  assign sym_acc       = symbols.valid && symbols.ready;
  assign store_ok      = (count < CNT_W'(MAX_SYMBOLS));
  assign count_inc     = store_ok ? CNT_W'(count + CNT_W'(1)) : count;
  assign node_goal     = NODE_W'((NODE_W'(n_leaves) << 1) - NODE_W'(1));
  assign merged_w      = NWT_W'(b1_w + b2_w);
  assign child_depth   = DEPTH_W'(cd_depth + DEPTH_W'(1));
  assign depth_ext     = {{LEN_W{1'b0}}, cd_depth};
  assign acc_sum       = ACC_W'(acc) + ACC_W'(prod);
  assign k_is_last     = (CNT_W'(k + CNT_W'(1)) == n_leaves);
  // drop both picked nodes, mark the new internal node live
  assign live_merged   = (live & ~(NODE_COUNT'(1) << b1_idx) & ~(NODE_COUNT'(1) << b2_idx))
                         | (NODE_COUNT'(1) << total);

  hcb_ram #(.WIDTH(NWORD_W), .DEPTH(NODE_COUNT), .ADDR_W(NODE_W)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_wa),
    .wdata (n_wd),
    .re    (n_re),
    .raddr (n_ra),
    .rdata (n_rd)
  );

  hcb_ram #(.WIDTH(CWORD_W), .DEPTH(NODE_COUNT), .ADDR_W(NODE_W)) u_code_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_wa),
    .wdata (c_wd),
    .re    (c_re),
    .raddr (c_ra),
    .rdata (c_rd)
  );

  always_comb begin
    n_we = 1'b0;
    n_wa = '0;
    n_wd = '0;
    n_re = 1'b0;
    n_ra = '0;
    c_we = 1'b0;
    c_wa = '0;
    c_wd = '0;
    c_re = 1'b0;
    c_ra = '0;
    unique case (state)
      S_LOAD: begin
        n_we = sym_acc && store_ok;
        n_wa = NODE_W'(count);
        n_wd = {symbols.symbol, {(2*NODE_W){1'b0}}, NWT_W'(symbols.weight)};
      end
      S_SCAN: begin
        n_re = (scan_idx < total);
        n_ra = scan_idx;
      end
      S_MERGE: begin
        n_we = 1'b1;
        n_wa = total;
        n_wd = {{SYM_W{1'b0}}, b1_idx, b2_idx, merged_w};
      end
      S_ROOT: begin
        c_we = 1'b1;
        c_wa = NODE_W'(total - NODE_W'(1));
        c_wd = '0;
      end
      S_WALK_RD: begin
        n_re = 1'b1;
        n_ra = walk_idx;
        c_re = 1'b1;
        c_ra = walk_idx;
      end
      S_WALK_ZERO: begin
        c_we = 1'b1;
        c_wa = nd_zc;
        c_wd = {child_depth, cd_code[CODE_W-2:0], 1'b0};
      end
      S_WALK_ONE: begin
        c_we = 1'b1;
        c_wa = nd_oc;
        c_wd = {child_depth, cd_code[CODE_W-2:0], 1'b1};
      end
      S_SUM_RD, S_OUT_RD: begin
        n_re = 1'b1;
        n_ra = NODE_W'(k);
        c_re = 1'b1;
        c_ra = NODE_W'(k);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      live      <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (sym_acc) begin
            if (store_ok) begin
              live[NODE_W'(count)] <= 1'b1;
            end
            count <= count_inc;
            if (symbols.last_symbol) begin
              n_leaves <= count_inc;
              total    <= NODE_W'(count_inc);
              scan_idx <= '0;
              pend_v   <= 1'b0;
              b1_v     <= 1'b0;
              b2_v     <= 1'b0;
              state    <= (count_inc == CNT_W'(1)) ? S_ROOT : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (n_re) begin
            scan_idx <= NODE_W'(scan_idx + NODE_W'(1));
          end
          pend_v   <= n_re;
          pend_idx <= scan_idx;
          // keep the two lightest live nodes; ties go to the lower index
          if (pend_v && live[pend_idx]) begin
            if (!b1_v || nd_wt < b1_w) begin
              b2_v   <= b1_v;
              b2_idx <= b1_idx;
              b2_w   <= b1_w;
              b1_v   <= 1'b1;
              b1_idx <= pend_idx;
              b1_w   <= nd_wt;
            end else if (!b2_v || nd_wt < b2_w) begin
              b2_v   <= 1'b1;
              b2_idx <= pend_idx;
              b2_w   <= nd_wt;
            end
          end
          if (scan_idx == total && !pend_v) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          live         <= live_merged;
          total        <= NODE_W'(total + NODE_W'(1));
          scan_idx     <= '0;
          pend_v       <= 1'b0;
          b1_v         <= 1'b0;
          b2_v         <= 1'b0;
          state <= (NODE_W'(total + NODE_W'(1)) == node_goal) ? S_ROOT : S_SCAN;
        end
        S_ROOT: begin
          walk_idx <= NODE_W'(total - NODE_W'(1));
          k        <= '0;
          acc      <= '0;
          state    <= (total > NODE_W'(n_leaves)) ? S_WALK_RD : S_SUM_RD;
        end
        S_WALK_RD: begin
          state <= S_WALK_ZERO;
        end
        S_WALK_ZERO: begin
          state <= S_WALK_ONE;
        end
        S_WALK_ONE: begin
          walk_idx <= NODE_W'(walk_idx - NODE_W'(1));
          state    <= (walk_idx == NODE_W'(n_leaves)) ? S_SUM_RD : S_WALK_RD;
        end
        S_SUM_RD: begin
          state <= S_SUM_MUL;
        end
        S_SUM_MUL: begin
          prod  <= PROD_W'(nd_wt[WEIGHT_BITS-1:0]) * PROD_W'(cd_depth);
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          acc <= (acc_sum > ACC_W'(hcb_pkg::EXP_MAX)) ? hcb_pkg::EXP_MAX : acc_sum[EXP_W-1:0];
          if (k_is_last) begin
            k     <= '0;
            state <= S_OUT_RD;
          end else begin
            k     <= CNT_W'(k + CNT_W'(1));
            state <= S_SUM_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LOAD;
        end
        S_OUT_LOAD: begin
          out_valid  <= 1'b1;
          out_symbol <= nd_sym;
          out_code   <= cd_code;
          out_len    <= depth_ext[LEN_W-1:0];
          out_last   <= k_is_last;
          state      <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (codes.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              live  <= '0;
              state <= S_LOAD;
            end else begin
              k     <= CNT_W'(k + CNT_W'(1));
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign codes.valid           = out_valid;
  assign codes.out_symbol      = out_symbol;
  assign codes.code_bits       = out_code;
  assign codes.code_length     = out_len;
  assign codes.expected_length = acc;
  assign codes.last_code       = out_last;

  // two distinct live nodes are always picked before a merge
  a_merge_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (b1_v && b2_v && b1_idx != b2_idx))
    else $error("merge without two distinct nodes");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SYMBOLS))
    else $error("fill count beyond store depth");

  // children always sit below their parent, so the walk writes ahead of its reads
  a_child_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_ZERO) |-> (nd_zc < walk_idx && nd_oc < walk_idx))
    else $error("child index not below parent");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.ready && codes.last_code) |=> (state == S_LOAD && count == '0
      && live == '0))
    else $error("builder not empty after final code word");

endmodule
